// ===== rtl/core/frame_rate_meter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame rate meter
// Shared property forms; each expects clk and rst in the using scope.
// ----------------------------------------------------------------------------
`ifndef FRAME_RATE_METER_UNIT_ASSERT_SVH
`define FRAME_RATE_METER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define FRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame rate meter: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define FRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame rate meter: next-cycle check failed");

`endif

// ===== rtl/core/frm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_pkg
// Item types, controller/datapath command and status groups, constants.
// ----------------------------------------------------------------------------
package frm_pkg;

  localparam int STAMP_W = 32;
  localparam int RATE_W  = 32;
  localparam int SCALE_W = 18;

  // 1000 ms per second times 256 for the Q24.8 result
  localparam logic [SCALE_W-1:0] RATE_SCALE = 18'd256000;

  // Function selector codes
  localparam logic FUNC_RESTART = 1'b0;
  localparam logic FUNC_FRAME   = 1'b1;

  typedef struct packed {
    logic               func;
    logic [STAMP_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [RATE_W-1:0] fps_q8;
    logic              zero_time;
  } result_t;

  typedef struct packed {
    logic clear;     // restart: empty the window, record the stamp
    logic start;     // frame: take the interval, read the oldest entry
    logic sub;       // drop the overwritten entry from the sum
    logic add;       // add the new interval, write the ring, advance
    logic mul;       // form the dividend, prime the divider
    logic div_step;  // one quotient bit
    logic load;      // move the rate into the output register
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic sum_zero;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/frm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module frm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/frm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_ctrl
// Sequencer for one item: window update, dividend, serial divide, result.
// ----------------------------------------------------------------------------
`include "frame_rate_meter_unit_assert.svh"

module frm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_func,
  output logic              item_stall,
  input  frm_pkg::status_t  status,
  output frm_pkg::cmd_t     cmd
);

  import frm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (item_func == FUNC_FRAME) begin
            cmd.start  = 1'b1;
            state_next = ST_SUB;
          end else begin
            cmd.clear  = 1'b1;
          end
        end
      end
      ST_SUB: begin
        cmd.sub    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = status.sum_zero ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Take items only between frames
  assign item_stall = (state != ST_IDLE);

  `FRM_ASSERT_NEXT(a_frame_enters_sub, state == ST_IDLE && item_valid && item_func == FUNC_FRAME, state == ST_SUB)
  `FRM_ASSERT_NEXT(a_restart_stays_idle, state == ST_IDLE && item_valid && item_func == FUNC_RESTART, state == ST_IDLE)
  `FRM_ASSERT_NEXT(a_div_runs_out, state == ST_DIV && !status.div_last, state == ST_DIV)

endmodule

// ===== rtl/core/frm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_datapath
// Interval ring, window sum, dividend multiply, radix-2 restoring divider
// and the output register.
// ----------------------------------------------------------------------------
`include "frame_rate_meter_unit_assert.svh"

module frm_datapath #(
  parameter int WINDOW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  frm_pkg::cmd_t     cmd,
  output frm_pkg::status_t  status,
  input  frm_pkg::item_t    item,
  input  logic              result_stall,
  output logic              result_valid,
  output frm_pkg::result_t  result
);

  import frm_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = STAMP_W + SLOT_W;
  localparam int NUM_W  = SCALE_W + FILL_W;
  localparam int CNT_W  = $clog2(NUM_W);

  logic [SLOT_W-1:0]  write_slot;
  logic [SLOT_W-1:0]  slot_next;
  logic [FILL_W-1:0]  filled;
  logic [SUM_W-1:0]   window_sum;
  logic [STAMP_W-1:0] last_stamp;
  logic [STAMP_W-1:0] interval;
  logic [STAMP_W-1:0] old_interval;
  logic [NUM_W-1:0]   num;
  logic [SUM_W-1:0]   rem;
  logic [CNT_W-1:0]   div_cnt;
  logic               sum_zero;
  logic               full;
  logic [SUM_W:0]     rem_shift;
  logic               rem_ge;
  logic [SUM_W:0]     rem_diff;

  assign full      = (filled == FILL_W'(WINDOW));
  assign slot_next = (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + SLOT_W'(1);

  // Interval ring
  frm_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.add),
    .wr_addr (write_slot),
    .wr_data (interval),
    .rd_en   (cmd.start),
    .rd_addr (write_slot),
    .rd_data (old_interval)
  );

  // One restoring divide step
  assign rem_shift = {rem, num[NUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, window_sum});
  assign rem_diff  = rem_shift - {1'b0, window_sum};

  // Window state, divider count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      filled       <= '0;
      window_sum   <= '0;
      last_stamp   <= '0;
      div_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        write_slot <= '0;
        filled     <= '0;
        window_sum <= '0;
        last_stamp <= item.now_ms;
      end
      if (cmd.start) begin
        last_stamp <= item.now_ms;
      end
      if (cmd.sub && full) begin
        window_sum <= window_sum - SUM_W'(old_interval);
      end
      if (cmd.add) begin
        window_sum <= window_sum + SUM_W'(interval);
        write_slot <= slot_next;
        if (!full) begin
          filled <= filled + FILL_W'(1);
        end
      end
      if (cmd.mul) begin
        div_cnt <= '0;
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + CNT_W'(1);
      end
      if (cmd.load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Interval, divider registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      interval <= item.now_ms - last_stamp;
    end
    if (cmd.mul) begin
      num      <= NUM_W'(RATE_SCALE) * NUM_W'(filled);
      rem      <= '0;
      sum_zero <= (window_sum == '0);
    end
    if (cmd.div_step) begin
      num <= {num[NUM_W-2:0], rem_ge};
      rem <= rem_ge ? rem_diff[SUM_W-1:0] : rem_shift[SUM_W-1:0];
    end
    if (cmd.load) begin
      result.fps_q8    <= sum_zero ? '1 : RATE_W'(num);
      result.zero_time <= sum_zero;
    end
  end

  assign status.div_last = (div_cnt == CNT_W'(NUM_W - 1));
  assign status.sum_zero = (window_sum == '0);
  assign status.out_free = !result_valid || !result_stall;

  `FRM_ASSERT_IMP(a_fill_bound, 1'b1, filled <= FILL_W'(WINDOW))
  `FRM_ASSERT_IMP(a_slot_bound, 1'b1, write_slot <= SLOT_W'(WINDOW - 1))
  `FRM_ASSERT_NEXT(a_load_shows, cmd.load, result_valid)
  `FRM_ASSERT_IMP(a_zero_saturates, result_valid && result.zero_time, result.fps_q8 == '1)

endmodule

// ===== rtl/core/frame_rate_meter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_meter_unit
// Restart gives no item. A frame passes through the states SUB, ADD, MUL, DIV
// and DONE before its item is given; the next item is taken only back in idle.
// NUM_W = 18 + clog2(WINDOW + 1) is the dividend width of the bit-serial
// divider, one quotient bit per cycle. A zero window sum skips the divider.
// Synchronous reset empties the window and zeroes the last timestamp.
// ----------------------------------------------------------------------------
module frame_rate_meter_unit #(
  parameter int WINDOW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  frm_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output frm_pkg::result_t  result
);

  import frm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  frm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_func  (item.func),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // Window and divider
  frm_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
